// File: src/sacl_pkg.sv
package sacl_pkg;

	localparam int RANK_W     = 3;
	localparam int RANK_CAP   = 7;
	localparam int OFFSET_MAX = 12;
	localparam int INDEX_MAX  = 9;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 4;

	localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE = 2'd2;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOKUP
	} state_t;

endpackage

// File: src/sacl_ram.sv
module sacl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                               clk,
	input  logic                               we,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
	input  logic [WIDTH-1:0]                   wdata,
	input  logic                               re,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
	output logic [WIDTH-1:0]                   rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: src/set_associative_cache_lru_tags_top.sv
// Flow: a beat accepted while start is high and busy is low reads its set row from the
//   set RAM; the LOOKUP state compares the tags and writes the row back, and done, hit
//   and way_touched are registered from LOOKUP. A new beat waits for the read-modify-write
//   of one set row: read in the accept cycle, compare and write back in LOOKUP, busy high.
// Reset: asynchronous, active low; then a clearing pass over all MAX_SETS set rows zeroes
//   the valid bits and ranks with busy held high. Results cannot be stalled by the receiver.
module set_associative_cache_lru_tags_top
	import sacl_pkg::*;
#(
	parameter int MAX_SETS   = 512,
	parameter int MAX_WAYS   = 8,
	parameter int ADDR_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [ADDR_WIDTH-1:0] address,
	output logic                  done,
	output logic                  hit,
	output logic [2:0]            way_touched,
	output logic [31:0]           hit_total,
	output logic [31:0]           miss_total,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int SET_W     = $clog2(MAX_SETS > 1 ? MAX_SETS : 2);
	localparam int WAY_W     = $clog2(MAX_WAYS > 1 ? MAX_WAYS : 2);
	localparam int WAY_LIMIT = (MAX_WAYS < 8) ? MAX_WAYS : 8;
	localparam int SET_FLOG  = $clog2(MAX_SETS + 1) - 1;
	localparam int IDX_LIMIT = (SET_FLOG < INDEX_MAX) ? SET_FLOG : INDEX_MAX;
	localparam int ENTRY_W   = ADDR_WIDTH + 1 + RANK_W;
	localparam int ROW_W     = MAX_WAYS * ENTRY_W;

	state_t state_q, state_nxt;

	logic [3:0]            offset_bits_q, index_bits_q, ways_in_use_q;
	logic [3:0]            ob_eff, ib_eff, ways_eff;
	logic [SET_W-1:0]      clr_q;
	logic [SET_W-1:0]      set_now, set_s1;
	logic [ADDR_WIDTH-1:0] tag_now, tag_s1, set_full;
	logic [31:0]           hits_q, misses_q;
	logic                  done_q, hit_q;
	logic [2:0]            way_q;

	logic                  accept;
	logic                  ram_we, ram_re;
	logic [SET_W-1:0]      ram_waddr;
	logic [ROW_W-1:0]      ram_wdata, ram_rdata;

	logic [MAX_WAYS-1:0][ENTRY_W-1:0] row_in, row_out;
	logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] way_tag;
	logic [MAX_WAYS-1:0]              way_vld;
	logic [MAX_WAYS-1:0][RANK_W-1:0]  way_rank;

	logic                  lk_hit, lk_inv;
	logic [WAY_W-1:0]      hit_way, inv_way, vic_way, touched;
	logic [RANK_W-1:0]     best_rank;
	logic [RANK_W:0]       old_rank;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_bits_q <= 4'd6;
			index_bits_q  <= 4'd4;
			ways_in_use_q <= 4'd1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_OFFSET_BITS: offset_bits_q <= cfg_data;
				CFG_INDEX_BITS:  index_bits_q  <= cfg_data;
				CFG_WAYS_IN_USE: ways_in_use_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		ob_eff = (offset_bits_q > 4'(OFFSET_MAX)) ? 4'(OFFSET_MAX) : offset_bits_q;
		ib_eff = (index_bits_q > 4'(IDX_LIMIT)) ? 4'(IDX_LIMIT) : index_bits_q;
		if (ways_in_use_q == 4'd0) begin
			ways_eff = 4'd1;
		end else if (ways_in_use_q > 4'(WAY_LIMIT)) begin
			ways_eff = 4'(WAY_LIMIT);
		end else begin
			ways_eff = ways_in_use_q;
		end
	end

	assign set_full = (address >> ob_eff) & ~({ADDR_WIDTH{1'b1}} << ib_eff);
	assign set_now  = set_full[SET_W-1:0];
	assign tag_now  = address >> ({1'b0, ob_eff} + {1'b0, ib_eff});
	assign accept   = start && !busy;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_CLEAR:  if (clr_q == SET_W'(MAX_SETS - 1)) state_nxt = ST_IDLE;
			ST_IDLE:   if (start) state_nxt = ST_LOOKUP;
			ST_LOOKUP: state_nxt = ST_IDLE;
			default:   state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		busy      = 1'b1;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_waddr = set_s1;
		ram_wdata = row_out;
		case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
			end
			ST_IDLE: begin
				busy   = 1'b0;
				ram_re = start;
			end
			ST_LOOKUP: begin
				ram_we = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			clr_q    <= '0;
			done_q   <= 1'b0;
			hits_q   <= '0;
			misses_q <= '0;
		end else begin
			state_q <= state_nxt;
			done_q  <= (state_q == ST_LOOKUP);
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + SET_W'(1);
			end
			if (state_q == ST_LOOKUP) begin
				if (lk_hit) begin
					if (hits_q != 32'hFFFF_FFFF) hits_q <= hits_q + 32'd1;
				end else begin
					if (misses_q != 32'hFFFF_FFFF) misses_q <= misses_q + 32'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			set_s1 <= set_now;
			tag_s1 <= tag_now;
		end
		if (state_q == ST_LOOKUP) begin
			hit_q <= lk_hit;
			way_q <= 3'(touched);
		end
	end

	sacl_ram #(
		.WIDTH(ROW_W),
		.DEPTH(MAX_SETS)
	) u_set_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(set_now),
		.rdata(ram_rdata)
	);

	assign row_in = ram_rdata;

	always_comb begin
		for (int w = 0; w < MAX_WAYS; w++) begin
			way_tag[w]  = row_in[w][ENTRY_W-1 -: ADDR_WIDTH];
			way_vld[w]  = row_in[w][RANK_W];
			way_rank[w] = row_in[w][RANK_W-1:0];
		end
	end

	always_comb begin
		lk_hit    = 1'b0;
		lk_inv    = 1'b0;
		hit_way   = '0;
		inv_way   = '0;
		vic_way   = '0;
		best_rank = '0;
		for (int w = MAX_WAYS - 1; w >= 0; w--) begin
			if (4'(w) < ways_eff && way_vld[w] && way_tag[w] == tag_s1) begin
				lk_hit  = 1'b1;
				hit_way = WAY_W'(w);
			end
			if (4'(w) < ways_eff && !way_vld[w]) begin
				lk_inv  = 1'b1;
				inv_way = WAY_W'(w);
			end
		end
		for (int w = 0; w < MAX_WAYS; w++) begin
			if (4'(w) < ways_eff && (way_rank[w] > best_rank || w == 0)) begin
				best_rank = way_rank[w];
				vic_way   = WAY_W'(w);
			end
		end
		if (lk_hit) begin
			touched = hit_way;
		end else if (lk_inv) begin
			touched = inv_way;
		end else begin
			touched = vic_way;
		end
	end

	always_comb begin
		old_rank = way_vld[touched] ? {1'b0, way_rank[touched]} : (RANK_W + 1)'(RANK_CAP + 1);
		row_out  = row_in;
		for (int w = 0; w < MAX_WAYS; w++) begin
			if (4'(w) < ways_eff && WAY_W'(w) != touched
					&& {1'b0, way_rank[w]} < old_rank && way_rank[w] < RANK_W'(RANK_CAP)) begin
				row_out[w][RANK_W-1:0] = way_rank[w] + RANK_W'(1);
			end
		end
		row_out[touched][RANK_W-1:0] = '0;
		if (!lk_hit) begin
			row_out[touched][RANK_W]               = 1'b1;
			row_out[touched][ENTRY_W-1 -: ADDR_WIDTH] = tag_s1;
		end
	end

	assign done        = done_q;
	assign hit         = hit_q;
	assign way_touched = way_q;
	assign hit_total   = hits_q;
	assign miss_total  = misses_q;

	a_done_after_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_LOOKUP))
		else $error("result strobe without a lookup");

	a_accept_to_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (state_q == ST_LOOKUP))
		else $error("accepted beat did not enter lookup");

	a_way_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ({1'b0, way_touched} < ways_eff))
		else $error("touched way beyond ways in use");

	a_one_total_moves: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(hit_total != $past(hit_total) && miss_total != $past(miss_total)))
		else $error("hit and miss totals both changed");

endmodule
